// ----- design/iirdf_pkg.sv -----
// Package with shared types, codes and constants of the direct-form IIR filter.
`timescale 1ns / 1ps

package iirdf_pkg;

    // Default parameter values.
    localparam int ORDER_DEFAULT       = 8;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int COEF_BITS_DEFAULT   = 24;

    // Fixed widths of the request fields and of the accumulator.
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 4;
    localparam int ACC_W  = 64;

    // Step counter wide enough for the step index (up to 2*ORDER, 16 at the default order).
    localparam int STEP_W = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FILTER  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_LOAD_A  = 2'd2,
        FUNC_LOAD_IC = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_MAC    = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              start;   // sample request taken: latch, clear histories on block start, seed accumulator
        logic              load;    // load request taken: write a register
        logic              mul;     // issue one product for the current step
        logic [STEP_W-1:0] step;    // product index
        logic              commit;  // write result and shift histories
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a new result this cycle
    } status_t;

endpackage

// ----- design/iirdf_ctrl.sv -----
// Controller state machine that sequences the shared multiply-accumulate.
`timescale 1ns / 1ps

module iirdf_ctrl
    import iirdf_pkg::*;
#(
    parameter int ORDER = ORDER_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FUNC_W-1:0]   func,
    input  status_t             status,
    output cmd_t                cmd
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * ORDER);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func == FUNC_FILTER)
                    begin
                        cmd.start  = 1'b1;
                        step_next  = '0;
                        state_next = ST_MAC;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mul = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/iirdf_dp.sv -----
// Datapath: coefficient and history registers, shared multiplier, accumulator, output register.
`timescale 1ns / 1ps

module iirdf_dp
    import iirdf_pkg::*;
#(
    parameter int ORDER       = ORDER_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter int COEF_BITS   = COEF_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output status_t                       status,
    input  logic [FUNC_W-1:0]             func,
    input  logic [IDX_W-1:0]              index,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic signed [COEF_BITS-1:0]   coefficient,
    input  logic                          block_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          saturated
);

    localparam int FRAC   = COEF_BITS - 4;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int BC_W   = $clog2(ORDER + 1);
    localparam int IC_IW  = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int HI_W   = ACC_W - FRAC - SAMPLE_BITS + 1;

    logic signed [COEF_BITS-1:0]   b_reg [0:ORDER];
    logic signed [COEF_BITS-1:0]   a_reg [0:ORDER-1];
    logic signed [SAMPLE_BITS-1:0] ic_reg [0:ORDER-1];
    logic signed [SAMPLE_BITS-1:0] xh_reg [0:ORDER-1];
    logic signed [SAMPLE_BITS-1:0] yh_reg [0:ORDER-1];
    logic [BC_W-1:0]               bc_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          sub_reg;
    logic                          prod_valid_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic                          sat_reg;

    logic [BC_W-1:0]               bc_eff;
    logic                          ic_active;
    logic signed [SAMPLE_BITS-1:0] ic_val;
    logic [ACC_W-1:0]              acc_init;
    logic signed [COEF_BITS-1:0]   coef_sel;
    logic signed [SAMPLE_BITS-1:0] samp_sel;
    logic                          sub_sel;
    logic signed [PROD_W-1:0]      prod_next;
    logic [ACC_W-1:0]              prod_ext;
    logic [HI_W-1:0]               acc_hi;
    logic                          ovf;
    logic signed [SAMPLE_BITS-1:0] y_val;

    // Block count after an optional block start, and the seed of the accumulator:
    // initial condition in the integer part plus half a sample step for rounding.
    always_comb
    begin
        bc_eff    = block_start ? '0 : bc_reg;
        ic_active = (bc_eff < BC_W'(ORDER));
        ic_val    = ic_active ? ic_reg[bc_eff[IC_IW-1:0]] : '0;
        acc_init  = {{(ACC_W - FRAC - SAMPLE_BITS){ic_val[SAMPLE_BITS-1]}}, ic_val,
                     1'b1, {(FRAC - 1){1'b0}}};
    end

    // Operand selection for the current step: b taps first, then a taps.
    always_comb
    begin
        coef_sel = '0;
        samp_sel = '0;
        sub_sel  = 1'b0;
        for (int i = 0; i <= ORDER; i++)
        begin
            if (cmd.step == STEP_W'(i))
            begin
                coef_sel = b_reg[i];
                samp_sel = (i == 0) ? x_reg : xh_reg[(i == 0) ? 0 : i - 1];
            end
        end
        for (int i = 0; i < ORDER; i++)
        begin
            if (cmd.step == STEP_W'(ORDER + 1 + i))
            begin
                coef_sel = a_reg[i];
                samp_sel = yh_reg[i];
                sub_sel  = 1'b1;
            end
        end
        prod_next = coef_sel * samp_sel;
    end

    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Round has been folded into the seed; only the saturation check remains.
    always_comb
    begin
        acc_hi = acc_reg[ACC_W-1:FRAC+SAMPLE_BITS-1];
        ovf    = !((&acc_hi) || !(|acc_hi));
        if (!ovf)
        begin
            y_val = acc_reg[FRAC+SAMPLE_BITS-1:FRAC];
        end
        else if (acc_reg[ACC_W-1])
        begin
            y_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end
        else
        begin
            y_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ORDER; i++)
            begin
                b_reg[i] <= '0;
            end
            for (int i = 0; i < ORDER; i++)
            begin
                a_reg[i]  <= '0;
                ic_reg[i] <= '0;
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
            bc_reg         <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.mul;
            if (cmd.load)
            begin
                case (func)
                    FUNC_LOAD_B:
                    begin
                        for (int i = 0; i <= ORDER; i++)
                        begin
                            if (index == IDX_W'(i))
                            begin
                                b_reg[i] <= coefficient;
                            end
                        end
                    end
                    FUNC_LOAD_A:
                    begin
                        for (int i = 0; i < ORDER; i++)
                        begin
                            if (index == IDX_W'(i + 1))
                            begin
                                a_reg[i] <= coefficient;
                            end
                        end
                    end
                    FUNC_LOAD_IC:
                    begin
                        for (int i = 0; i < ORDER; i++)
                        begin
                            if (index == IDX_W'(i))
                            begin
                                ic_reg[i] <= sample_in;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.start)
            begin
                bc_reg <= ic_active ? bc_eff + 1'b1 : bc_eff;
                if (block_start)
                begin
                    for (int i = 0; i < ORDER; i++)
                    begin
                        xh_reg[i] <= '0;
                        yh_reg[i] <= '0;
                    end
                end
            end
            if (cmd.commit)
            begin
                xh_reg[0] <= x_reg;
                yh_reg[0] <= y_val;
                for (int i = 1; i < ORDER; i++)
                begin
                    xh_reg[i] <= xh_reg[i-1];
                    yh_reg[i] <= yh_reg[i-1];
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg   <= sample_in;
            acc_reg <= acc_init;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            sub_reg  <= sub_sel;
        end
        if (cmd.commit)
        begin
            out_data_reg <= y_val;
            sat_reg      <= ovf;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_out      = out_data_reg;
    assign saturated       = sat_reg;

endmodule

// ----- design/iir_direct_form_filter_top.sv -----
// Top level of the direct-form IIR filter: controller and datapath.
`timescale 1ns / 1ps

// Channel  Handshake              Carries
// input    in_valid / in_ready    func, index, sample_in, coefficient, block_start
// output   out_valid / out_ready  sample_out, saturated
//
// A load request (func 1 to 3) writes its register, leaves the input ready in the next cycle and gives no result.
// A sample request keeps the input busy from acceptance until its result is committed:
// one multiply-accumulate is issued per tap through the single shared multiplier,
// followed by a drain state and a commit state that waits for a free output.
// Reset clears all coefficients, initial conditions, histories and the block count.
// The result sits in an output register, so a new request can be taken while it waits;
// only the commit of the following sample stalls until the output is free.

module iir_direct_form_filter_top
    import iirdf_pkg::*;
#(
    parameter int ORDER       = ORDER_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter int COEF_BITS   = COEF_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [FUNC_W-1:0]             func,
    input  logic [IDX_W-1:0]              index,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic signed [COEF_BITS-1:0]   coefficient,
    input  logic                          block_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          saturated
);

    // Commands and status between the sequencer and the arithmetic.
    cmd_t    cmd;
    status_t status;

    // The controller walks through the b taps and then the a taps, one per cycle.
    iirdf_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the filter state and produces the rounded, saturated result.
    iirdf_dp #(
        .ORDER       (ORDER),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (func),
        .index       (index),
        .sample_in   (sample_in),
        .coefficient (coefficient),
        .block_start (block_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .saturated   (saturated)
    );

endmodule

// ----- design/iirdf_checker.sv -----
// Port-level checker for the direct-form IIR filter and its bind to the top level.
`timescale 1ns / 1ps

module iirdf_checker
    import iirdf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [FUNC_W-1:0]      func,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample_out,
    input logic                   saturated
);

    localparam logic [SAMPLE_BITS-1:0] MAX_VAL = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated))
        else $error("result changed while stalled");

    // A sample request keeps the filter busy on the next cycle.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_FILTER |=> !in_ready)
        else $error("new request taken while a sample is in progress");

    // A load request leaves the input ready in the next cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func != FUNC_FILTER |=> in_ready)
        else $error("load request stalled the input");

    // A clipped result is one of the two range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> sample_out == MAX_VAL || sample_out == MIN_VAL)
        else $error("saturated result not at a range limit");

endmodule

bind iir_direct_form_filter_top iirdf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_iirdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .saturated  (saturated)
);
